// File: hw/rtl/skf_pkg.sv
// skf_pkg: types and constants for the scalar Kalman filter.
// No dependencies; imported by scalar_kalman_filter.
package skf_pkg;

    typedef logic [31:0] cov_t;   // covariance, Q2.30
    typedef logic [30:0] gain_t;  // gain and noise registers, Q1.30
    typedef logic [27:0] est_t;   // estimate, Q12.16
    typedef logic [11:0] meas_t;  // raw ADC code

    localparam int CFG_AW = 1;
    typedef logic [CFG_AW-1:0] cfg_addr_t;

    localparam cfg_addr_t REG_PROCESS_NOISE = 1'd0;
    localparam cfg_addr_t REG_MEASURE_NOISE = 1'd1;

    localparam gain_t ONE_Q30     = 31'h4000_0000;
    localparam gain_t Q_RESET     = 31'd107374;
    localparam gain_t R_RESET     = 31'd10737418;
    localparam cov_t  COV_RESET   = 32'h4000_0000;
    localparam cov_t  COV_MAX     = 32'hFFFF_FFFF;

    localparam int    GAIN_BITS   = 31;
    localparam int    DIV_CNT_W   = 5;

endpackage

// File: hw/rtl/scalar_kalman_filter.sv
// scalar_kalman_filter: one-dimensional Kalman filter on 12-bit ADC samples.
// Depends on skf_pkg.
//
// Each sample runs from the input transaction through the covariance
// prediction, the divisor, the bit-serial gain division (one quotient bit per
// cycle through a single 34-bit subtractor), the two products, which share one
// 32x32 multiplier, and the output load. s_tready is high only while the
// sequencer is idle, so no new sample is taken before the last one is through;
// the next sample can be taken in the cycle after the result load. A
// finished result waits in the output register and does not hold off the next
// sample; only a second result that finds the register still full waits for
// m_tready. The user must write Q and R through cfg_we/cfg_addr/cfg_wdata only
// while the filter is idle; the block itself does not enforce this.
module scalar_kalman_filter (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [15:0]              s_tdata,   // [11:0] measurement
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [63:0]              m_tdata,   // [27:0] estimate, [58:28] gain
    input  logic                     cfg_we,
    input  skf_pkg::cfg_addr_t       cfg_addr,
    input  skf_pkg::gain_t           cfg_wdata
);
    import skf_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PRED = 3'd1;
    localparam logic [2:0] S_DEN  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_MULX = 3'd4;
    localparam logic [2:0] S_UPDX = 3'd5;
    localparam logic [2:0] S_UPDP = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    logic [2:0]           state_reg, state_next;
    gain_t                q_reg, q_next;
    gain_t                r_reg, r_next;
    est_t                 est_reg, est_next;
    cov_t                 cov_reg, cov_next;
    est_t                 z_reg, z_next;
    cov_t                 ppred_reg, ppred_next;
    logic [32:0]          den_reg, den_next;
    logic                 zden_reg, zden_next;
    logic [33:0]          rem_reg, rem_next;
    gain_t                quo_reg, quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    gain_t                k_reg, k_next;
    est_t                 diff_reg, diff_next;
    logic                 up_reg, up_next;
    logic [61:0]          prod_reg, prod_next;
    logic                 mvalid_reg, mvalid_next;
    est_t                 oest_reg, oest_next;
    gain_t                ogain_reg, ogain_next;

    logic [32:0]          pred_sum;
    logic [33:0]          rem_sh;
    logic                 rem_ge;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_p;
    est_t                 corr;

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {5'd0, ogain_reg, oest_reg};

    assign pred_sum = {1'b0, cov_reg} + {2'b0, q_reg};
    assign rem_sh   = (cnt_reg == '0) ? rem_reg : {rem_reg[32:0], 1'b0};
    assign rem_ge   = (rem_sh >= {1'b0, den_reg});
    assign corr     = prod_reg[57:30];

    // shared multiplier: correction term, then covariance update
    always_comb
    begin
        if (state_reg == S_MULX)
        begin
            mul_a = {1'b0, k_reg};
            mul_b = {4'd0, diff_reg};
        end
        else
        begin
            mul_a = {1'b0, ONE_Q30 - k_reg};
            mul_b = ppred_reg;
        end
    end
    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        state_next  = state_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        est_next    = est_reg;
        cov_next    = cov_reg;
        z_next      = z_reg;
        ppred_next  = ppred_reg;
        den_next    = den_reg;
        zden_next   = zden_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        k_next      = k_reg;
        diff_next   = diff_reg;
        up_next     = up_reg;
        prod_next   = prod_reg;
        mvalid_next = mvalid_reg;
        oest_next   = oest_reg;
        ogain_next  = ogain_reg;

        if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_PROCESS_NOISE: q_next = cfg_wdata;
                REG_MEASURE_NOISE: r_next = cfg_wdata;
                default: ;
            endcase
        end

        if (mvalid_reg && m_tready)
            mvalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    z_next     = {s_tdata[11:0], 16'd0};
                    state_next = S_PRED;
                end
            end
            S_PRED:
            begin
                ppred_next = pred_sum[32] ? COV_MAX : pred_sum[31:0];
                up_next    = (z_reg >= est_reg);
                diff_next  = (z_reg >= est_reg) ? z_reg - est_reg : est_reg - z_reg;
                state_next = S_DEN;
            end
            S_DEN:
            begin
                den_next   = {1'b0, ppred_reg} + {2'b0, r_reg};
                zden_next  = (ppred_reg == '0) && (r_reg == '0);
                rem_next   = {2'b0, ppred_reg};
                quo_next   = '0;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                rem_next = rem_ge ? rem_sh - {1'b0, den_reg} : rem_sh;
                quo_next = {quo_reg[GAIN_BITS-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_CNT_W'(GAIN_BITS - 1))
                begin
                    k_next     = zden_reg ? ONE_Q30 : {quo_reg[GAIN_BITS-2:0], rem_ge};
                    state_next = S_MULX;
                end
            end
            S_MULX:
            begin
                prod_next  = mul_p[61:0];
                state_next = S_UPDX;
            end
            S_UPDX:
            begin
                est_next   = up_reg ? est_reg + corr : est_reg - corr;
                prod_next  = mul_p[61:0];
                state_next = S_UPDP;
            end
            S_UPDP:
            begin
                cov_next   = prod_reg[61:30];
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    oest_next   = est_reg;
                    ogain_next  = k_reg;
                    mvalid_next = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            q_reg      <= Q_RESET;
            r_reg      <= R_RESET;
            est_reg    <= '0;
            cov_reg    <= COV_RESET;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            q_reg      <= q_next;
            r_reg      <= r_next;
            est_reg    <= est_next;
            cov_reg    <= cov_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        z_reg     <= z_next;
        ppred_reg <= ppred_next;
        den_reg   <= den_next;
        zden_reg  <= zden_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        k_reg     <= k_next;
        diff_reg  <= diff_next;
        up_reg    <= up_next;
        prod_reg  <= prod_next;
        oest_reg  <= oest_next;
        ogain_reg <= ogain_next;
    end

`ifndef SYNTHESIS
    a_gain_le_one: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[58:28] <= ONE_Q30))
        else $error("gain above 1.0");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (cnt_reg <= DIV_CNT_W'(GAIN_BITS - 1)))
        else $error("divider step count out of range");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> (state_reg == S_PRED))
        else $error("accepted sample did not start prediction");

    a_cov_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDP) |=> (cov_reg <= $past(ppred_reg)))
        else $error("updated covariance above prediction");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(mvalid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside completion");
`endif

endmodule
